// ===== sv/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, status codes and the slot word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   // Table geometry.
   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int KEY_MAX  = 16;
   localparam int KIDX_W   = $clog2(KEY_MAX);
   localparam int KLEN_W   = KIDX_W + 1;
   localparam int PCNT_W   = SLOT_W + 1;

   // FNV-1a 64-bit constants.
   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

   // Register reset value.
   localparam logic [10:0] MAX_FILL_RESET = 11'd717;

   // Status codes.
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_UPDATED   = 3'd3;
   localparam logic [2:0] ST_REFUSED   = 3'd4;

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // One table slot as held in the slot memory.
   typedef struct packed {
      logic                   used;
      logic [KLEN_W-1:0]      klen;
      logic [31:0]            value;
      logic [KEY_MAX*8-1:0]   key;
   } slot_word_type;

   localparam int SLOT_WORD_W = $bits(slot_word_type);

endpackage

`default_nettype wire

// ===== sv/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single port RAM
// Reads every cycle and writes on enable at one address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable, read every cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table
// String keys hashed with FNV-1a 64, open addressing with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   A key arrives one byte per request beat (start high while busy is low).
//   Each byte beat is folded into the hash as it is taken. The beat
//   with req_key_last set runs a get or put and raises busy until done.
//   Exactly one response beat follows each key_last beat: rsp_strobe is high
//   for one cycle with status, value and slot. The receiver cannot stall.
//   The operation launches, then each probed slot takes one memory read and
//   one compare; the probe loop through the single slot memory port sets the
//   pace, and from 1 to 1024 slots are probed. An overlong key answers from
//   the launch step without probing.
//   After reset the block sweeps all 1024 slots of the slot memory to clear
//   the used marks; busy is high meanwhile. The fill limit register is written
//   through csr_valid/csr_ready; the user must write it only while no operation
//   is in flight, as the block does not enforce this. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_key_last,
   input  wire logic [31:0] req_value,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_result_value,
   output logic [9:0]       rsp_slot_index,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_max_fill
);

   // Sequencer codes.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [10:0]        max_fill_ff, max_fill_in;
   logic [10:0]        entry_ff, entry_in;
   logic [63:0]        hash_ff, hash_in;
   logic [KLEN_W-1:0]  klen_ff, klen_in;
   logic               kovf_ff, kovf_in;
   logic [7:0]         kbuf_ff [KEY_MAX];
   logic [7:0]         kbuf_in [KEY_MAX];
   logic               op_ff, op_in;
   logic [31:0]        val_ff, val_in;
   logic               strobe_ff, strobe_in;
   logic [2:0]         status_ff, status_in;
   logic [31:0]        rval_ff, rval_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               accept;
   logic [63:0]        hx;
   logic [63:0]        hnext;
   logic               key_done;
   logic               key_match;
   logic [KEY_MAX*8-1:0] key_row;
   logic [PCNT_W-1:0]  pcnt_inc;

   logic               ram_we;
   logic [SLOT_W-1:0]  ram_addr;
   slot_word_type      ram_wdata;
   slot_word_type      ram_rdata;
   logic [SLOT_WORD_W-1:0] ram_rbits;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // FNV-1a step: xor the byte, multiply by 2^40 + 435 as shifts and adds.
   assign hx    = hash_ff ^ {56'd0, req_key_byte};
   assign hnext = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5) + (hx << 4)
                + (hx << 1) + hx;

   // Key buffer packed as one memory row.
   always_comb begin
      for (int i = 0; i < KEY_MAX; i++) begin
         key_row[i*8 +: 8] = kbuf_ff[i];
      end
   end

   // Stored key compare: length first, then every byte below the length.
   always_comb begin
      key_match = (ram_rdata.klen == klen_ff);
      for (int i = 0; i < KEY_MAX; i++) begin
         if ((KLEN_W'(i) < klen_ff) && (ram_rdata.key[i*8 +: 8] != kbuf_ff[i])) begin
            key_match = 1'b0;
         end
      end
   end

   assign ram_rdata = slot_word_type'(ram_rbits);
   assign pcnt_inc  = pcnt_ff + 1'b1;

   // Sequencer and key collection.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pcnt_in     = pcnt_ff;
      max_fill_in = max_fill_ff;
      entry_in    = entry_ff;
      hash_in     = hash_ff;
      klen_in     = klen_ff;
      kovf_in     = kovf_ff;
      kbuf_in     = kbuf_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      rval_in     = rval_ff;
      slot_in     = slot_ff;
      key_done    = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = idx_ff;
      ram_wdata   = '{used: 1'b1, klen: klen_ff, value: val_ff, key: key_row};

      if (csr_valid) begin
         max_fill_in = csr_max_fill;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == SLOT_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_has_byte) begin
                  hash_in = hnext;
                  if (klen_ff < KLEN_W'(KEY_MAX)) begin
                     kbuf_in[klen_ff[KIDX_W-1:0]] = req_key_byte;
                     klen_in = klen_ff + 1'b1;
                  end else begin
                     kovf_in = 1'b1;
                  end
               end
               if (req_key_last) begin
                  op_in    = req_operation;
                  val_in   = req_value;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_LAUNCH: begin
            if (kovf_ff) begin
               status_in = ST_REFUSED;
               rval_in   = '0;
               slot_in   = '0;
               key_done  = 1'b1;
            end else begin
               idx_in   = hash_ff[SLOT_W-1:0];
               pcnt_in  = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            rval_in = '0;
            slot_in = '0;
            if (!ram_rdata.used) begin
               // Free slot ends the probe.
               if ((op_ff == OP_PUT) && (entry_ff < max_fill_ff)) begin
                  ram_we    = 1'b1;
                  entry_in  = entry_ff + 1'b1;
                  status_in = ST_INSERTED;
                  slot_in   = idx_ff;
               end else begin
                  status_in = (op_ff == OP_PUT) ? ST_REFUSED : ST_NOT_FOUND;
               end
               key_done = 1'b1;
            end else if (key_match) begin
               // Hit: read the value or overwrite it.
               if (op_ff == OP_GET) begin
                  status_in = ST_FOUND;
                  rval_in   = ram_rdata.value;
               end else begin
                  ram_we    = 1'b1;
                  status_in = ST_UPDATED;
               end
               slot_in  = idx_ff;
               key_done = 1'b1;
            end else if (pcnt_inc == PCNT_W'(CAPACITY)) begin
               // Every slot visited without a match or a free slot.
               status_in = (op_ff == OP_PUT) ? ST_REFUSED : ST_NOT_FOUND;
               key_done  = 1'b1;
            end else begin
               pcnt_in  = pcnt_inc;
               idx_in   = idx_ff + 1'b1;
               state_in = S_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Finish: emit the response beat and start a fresh key.
      if (key_done) begin
         strobe_in = 1'b1;
         state_in  = S_IDLE;
         hash_in   = FNV_BASIS;
         klen_in   = '0;
         kovf_in   = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         idx_ff      <= '0;
         pcnt_ff     <= '0;
         max_fill_ff <= MAX_FILL_RESET;
         entry_ff    <= '0;
         hash_ff     <= FNV_BASIS;
         klen_ff     <= '0;
         kovf_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         pcnt_ff     <= pcnt_in;
         max_fill_ff <= max_fill_in;
         entry_ff    <= entry_in;
         hash_ff     <= hash_in;
         klen_ff     <= klen_in;
         kovf_ff     <= kovf_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kbuf_ff   <= kbuf_in;
      op_ff     <= op_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      slot_ff   <= slot_in;
   end

   // Slot memory: used mark, length, value and key row in one word.
   lpht_ram #(
      .WIDTH (SLOT_WORD_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rbits)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = rval_ff;
   assign rsp_slot_index   = slot_ff[9:0];

endmodule

`default_nettype wire

// ===== bench/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives keys a byte per beat, mirrors the table in a behavioral predictor
// and checks every response beat against it, field by field, in order.
// ----------------------------------------------------------------------------

module tb_linear_probe_hash_table
   import lpht_pkg::*;
();

   localparam logic [63:0] HASH_MULT  = 64'h0000_0100_0000_01B3;
   localparam int          STALL_MAX  = 20000;
   localparam int          POOL_N     = 24;
   localparam int          KEY_SPAN   = KEY_MAX + 2;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
      logic [9:0]  slot;
   } table_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [7:0]  req_key_byte = 8'd0;
   logic        req_has_byte = 1'b0;
   logic        req_key_last = 1'b0;
   logic [31:0] req_value = 32'd0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_value;
   logic [9:0]  rsp_slot_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_max_fill = 11'd0;

   // Mirror of the table contents.
   logic                 tbl_used  [CAPACITY];
   logic [KLEN_W-1:0]    tbl_len   [CAPACITY];
   logic [KEY_MAX*8-1:0] tbl_key   [CAPACITY];
   logic [31:0]          tbl_value [CAPACITY];
   int unsigned          tbl_count;
   logic [10:0]          fill_limit;
   logic [KEY_MAX*8-1:0] cur_key;
   int unsigned          cur_len;
   logic                 cur_long;
   logic [63:0]          cur_hash;

   table_answer_type     pending_answers [$];
   int unsigned          mismatches;
   int unsigned          answers_seen;
   int unsigned          beats_sent;
   int unsigned          stall_cycles;
   bit                   no_idle;

   logic [KEY_SPAN*8-1:0] pool_key [POOL_N];
   int unsigned           pool_len [POOL_N];

   linear_probe_hash_table dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_key_byte     (req_key_byte),
      .req_has_byte     (req_has_byte),
      .req_key_last     (req_key_last),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_slot_index   (rsp_slot_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_fill     (csr_max_fill)
   );

   always #5 clock = ~clock;

   // Fold one accepted beat into the mirror; a last beat yields one answer.
   task automatic predict_beat(input logic op, input logic [7:0] kb, input logic has,
                               input logic last, input logic [31:0] val);
      table_answer_type ans;
      int unsigned   idx;
      int unsigned   n;
      logic [KEY_MAX*8-1:0] mask;
      if (has) begin
         cur_hash = (cur_hash ^ {56'd0, kb}) * HASH_MULT;
         if (cur_len < KEY_MAX) begin
            cur_key[8*cur_len +: 8] = kb;
            cur_len++;
         end else begin
            cur_long = 1'b1;
         end
      end
      if (!last) return;
      ans = '{status: ST_NOT_FOUND, value: 32'd0, slot: 10'd0};
      if (cur_long) begin
         ans.status = ST_REFUSED;
      end else begin
         mask = '0;
         for (int i = 0; i < KEY_MAX; i++)
            if (i < cur_len) mask[8*i +: 8] = 8'hFF;
         idx = 32'(cur_hash[SLOT_W-1:0]);
         ans.status = (op == OP_GET) ? ST_NOT_FOUND : ST_REFUSED;
         for (n = 0; n < CAPACITY; n++) begin
            if (!tbl_used[idx]) begin
               if (op == OP_PUT && tbl_count < fill_limit) begin
                  tbl_used[idx]  = 1'b1;
                  tbl_len[idx]   = KLEN_W'(cur_len);
                  tbl_key[idx]   = cur_key & mask;
                  tbl_value[idx] = val;
                  tbl_count++;
                  ans.status = ST_INSERTED;
                  ans.slot   = 10'(idx);
               end
               break;
            end
            if (tbl_len[idx] == cur_len && tbl_key[idx] == (cur_key & mask)) begin
               if (op == OP_GET) begin
                  ans.status = ST_FOUND;
                  ans.value  = tbl_value[idx];
               end else begin
                  tbl_value[idx] = val;
                  ans.status = ST_UPDATED;
               end
               ans.slot = 10'(idx);
               break;
            end
            idx = (idx + 1) % CAPACITY;
         end
      end
      pending_answers.push_back(ans);
      cur_key  = '0;
      cur_len  = 0;
      cur_long = 1'b0;
      cur_hash = FNV_BASIS;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Present one request beat, hold it until taken, then idle at random.
   task automatic send_beat(input logic op, input logic [7:0] kb, input logic has,
                            input logic last, input logic [31:0] val);
      int unsigned gap;
      start         <= 1'b1;
      req_operation <= op;
      req_key_byte  <= kb;
      req_has_byte  <= has;
      req_key_last  <= last;
      req_value     <= val;
      do @(posedge clock); while (busy);
      beats_sent++;
      predict_beat(op, kb, has, last, val);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Send a whole key; the last byte ends it unless a separate empty beat does.
   task automatic send_key(input logic op, input logic [KEY_SPAN*8-1:0] key,
                           input int unsigned len, input logic [31:0] val,
                           input bit sep_last);
      if (len == 0) begin
         send_beat(op, 8'($urandom), 1'b0, 1'b1, val);
         return;
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b0, $urandom);
         if (i == len - 1 && !sep_last)
            send_beat(op, key[8*i +: 8], 1'b1, 1'b1, val);
         else
            send_beat(1'($urandom), key[8*i +: 8], 1'b1, 1'b0, $urandom);
      end
      if (sep_last) send_beat(op, 8'($urandom), 1'b0, 1'b1, val);
   endtask

   // Hold the sender until every expected response has come back.
   task automatic drain_answers();
      start <= 1'b0;
      while (pending_answers.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fill_limit(input logic [10:0] limit);
      drain_answers();
      csr_valid    <= 1'b1;
      csr_max_fill <= limit;
      do @(posedge clock); while (!csr_ready);
      fill_limit = limit;
      csr_valid <= 1'b0;
   endtask

   // Boundary keys and values, empty key, overlong key, update and lookup.
   task automatic test_directed();
      logic [KEY_SPAN*8-1:0] k;
      no_idle = 1'b0;
      send_key(OP_GET, '0, 0, 32'h1234_5678, 1'b0);
      send_key(OP_PUT, '0, 0, 32'h0000_0000, 1'b0);
      send_key(OP_GET, '0, 0, 32'h0, 1'b0);
      send_key(OP_PUT, '0, 0, 32'hFFFF_FFFF, 1'b1);
      send_key(OP_GET, '0, 0, 32'h0, 1'b0);
      send_key(OP_PUT, '0, 1, 32'hA5A5_A5A5, 1'b0);
      k = {KEY_SPAN{8'hFF}};
      send_key(OP_PUT, k, 1, 32'h5A5A_5A5A, 1'b0);
      send_key(OP_GET, '0, 1, 32'h0, 1'b0);
      send_key(OP_GET, k, 1, 32'h0, 1'b1);
      send_key(OP_PUT, k, KEY_MAX, 32'hDEAD_BEEF, 1'b0);
      send_key(OP_GET, k, KEY_MAX, 32'h0, 1'b1);
      send_key(OP_PUT, k, KEY_MAX + 1, 32'h1, 1'b0);
      send_key(OP_GET, k, KEY_MAX + 2, 32'h0, 1'b1);
      send_key(OP_GET, k, KEY_MAX - 1, 32'h0, 1'b0);
      k = (KEY_SPAN*8)'({8'h61, 8'h62});
      send_key(OP_PUT, k, 2, 32'h0000_0001, 1'b0);
      k = (KEY_SPAN*8)'({8'h62, 8'h61});
      send_key(OP_GET, k, 2, 32'h0, 1'b0);
      send_key(OP_PUT, k, 2, 32'h8000_0000, 1'b0);
      send_key(OP_GET, k, 2, 32'h0, 1'b0);
   endtask

   // Mostly keys from a small pool so lookups and updates hit; some fresh.
   task automatic test_random_traffic(input int unsigned keys);
      logic [KEY_SPAN*8-1:0] k;
      int unsigned           len;
      int unsigned           p;
      for (int i = 0; i < POOL_N; i++) begin
         for (int j = 0; j < KEY_SPAN; j++) pool_key[i][8*j +: 8] = 8'($urandom);
         pool_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(KEY_MAX - 2, KEY_SPAN)
                                                    : $urandom_range(0, 6);
      end
      for (int i = 0; i < keys; i++) begin
         if (i % 60 == 0) no_idle = ~no_idle;
         if (i % 70 == 35) drain_answers();
         if (i == keys / 2) write_fill_limit(11'($urandom_range(tbl_count + 5, 900)));
         if ($urandom_range(0, 4) != 0) begin
            p = $urandom_range(0, POOL_N - 1);
            k = pool_key[p];
            len = pool_len[p];
         end else begin
            for (int j = 0; j < KEY_SPAN; j++) k[8*j +: 8] = 8'($urandom);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, KEY_SPAN)
                                               : $urandom_range(1, 4);
         end
         send_key(1'($urandom), k, len, $urandom, $urandom_range(0, 4) == 0);
      end
   endtask

   // Fill limit refusals, update despite the limit, inserts up to a new limit.
   task automatic test_fill_limit();
      no_idle = 1'b0;
      write_fill_limit(11'd1);
      send_key(OP_PUT, {KEY_SPAN{8'hC3}}, 5, 32'h1111_1111, 1'b0);
      send_key(OP_PUT, '0, 0, 32'h2222_2222, 1'b0);
      send_key(OP_GET, {KEY_SPAN{8'hC3}}, 5, 32'h0, 1'b0);
      write_fill_limit(11'(tbl_count + 2));
      for (int i = 0; i < 4; i++)
         send_key(OP_PUT, {KEY_SPAN{8'(8'h70 + i)}}, 7, $urandom, 1'b0);
      write_fill_limit(11'd1024);
      send_key(OP_GET, {KEY_SPAN{8'h3C}}, 3, 32'h0, 1'b0);
      send_key(OP_PUT, {KEY_SPAN{8'h3C}}, 3, 32'h0, 1'b0);
      send_key(OP_GET, '0, 2, 32'h0, 1'b0);
   endtask

   // Compare each response beat with the oldest expected answer.
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response status %0d value %h slot %0d",
                        $realtime, rsp_status, rsp_result_value, rsp_slot_index);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_result_value !== want.value ||
                rsp_slot_index !== want.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch status %0d/%0d value %h/%h slot %0d/%0d",
                           $realtime, want.status, rsp_status, want.value,
                           rsp_result_value, want.slot, rsp_slot_index);
            end
         end
      end
   end

   // Watchdog on cycles with no beat moving in either direction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1 || csr_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         tbl_used[i]  = 1'b0;
         tbl_len[i]   = '0;
         tbl_key[i]   = '0;
         tbl_value[i] = '0;
      end
      tbl_count    = 0;
      fill_limit   = MAX_FILL_RESET;
      cur_key      = '0;
      cur_len      = 0;
      cur_long     = 1'b0;
      cur_hash     = FNV_BASIS;
      mismatches   = 0;
      answers_seen = 0;
      beats_sent   = 0;
      stall_cycles = 0;
      no_idle      = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(65);
      test_fill_limit();
      write_fill_limit(MAX_FILL_RESET);

      drain_answers();
      repeat (40) @(posedge clock);
      $display("Sent %0d request beats, checked %0d responses (%0d entries held).",
               beats_sent, answers_seen, tbl_count);
      $display("Covered empty, maximal and overlong keys, updates and fill limit refusals.");
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
